@@ rtl/table_2d_inverse_interpolator_defines.svh @@
// Assertion macros shared by the checker.
`ifndef TABLE_2D_INVERSE_INTERPOLATOR_DEFINES_SVH
`define TABLE_2D_INVERSE_INTERPOLATOR_DEFINES_SVH

`define T2I_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define T2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/t2i_pkg.sv @@
`timescale 1ns / 1ps
package t2i_pkg;
  localparam int VALUE_BITS = 16;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_CELL    = 2'd1,
    CMD_ROW_REF = 2'd2,
    CMD_COL_REF = 2'd3
  } cmd_t;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,
    OP_ROW_RD0,
    OP_ROW_RD1,
    OP_ROW_TEST,
    OP_CELL_RD0,
    OP_CELL_RD1,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_COL_TEST,
    OP_CREF_RD0,
    OP_CREF_RD1,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_go;
  } t2i_cmd_t;

  typedef struct packed {
    logic is_query;
    logic row_hit;
    logic row_last;
    logic col_pass;
    logic col_done;
    logic col_hit;
    logic col_last;
    logic div_done;
  } t2i_status_t;
endpackage

@@ rtl/table_2d_inverse_interpolator.sv @@
`timescale 1ns / 1ps
// Two-dimensional table compensator with inverse lookup along the columns.
// Input channel in_*: one transaction carries a command. Cell, row reference
// and column reference writes load the table and give no result; a query
// gives exactly one result on out_* (compensated value and in_range flag).
// Configuration: cfg_we with cfg_addr 0 (rows in use) or 1 (columns in use).
// A query walks the row references (two reads and a test per row), then
// interpolates each column through one shared multiply and shift-subtract
// divider, tests column brackets one per cycle and runs one more division.
// With the default sizes a query runs up to 9 divisions. One item is in
// work at a time. The result sits in an output register; the next item is
// taken while it waits, and the block stalls before finishing a query until
// it is taken. Reset clears the counts and control state; table contents
// stay undefined until written.
module table_2d_inverse_interpolator
  import t2i_pkg::*;
#(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], row_index[5:2], col_index[8:6], write_value, measured_value,
  // condition_value, zero fill
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_value[15:0]
  output logic [15:0] out_tdata,
  // in_range
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata
);
  localparam int VB  = VALUE_BITS;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [RCW-1:0] rows_r;
  logic [CCW-1:0] cols_r;
  logic           ovalid_r;
  logic [15:0]    odata_r;
  logic           ouser_r;
  logic           busy, emit, in_fire;
  t2i_cmd_t       cmd;
  t2i_status_t    status;
  logic signed [VB-1:0] res_value;
  logic           res_ok;

  assign in_tready  = !busy;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= '0;
      cols_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == REG_ROWS)
        rows_r <= (32'(cfg_wdata) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg_wdata);
      if (cfg_we && cfg_addr == REG_COLS)
        cols_r <= (32'(cfg_wdata) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cfg_wdata);
      if (emit) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
    if (emit) begin
      odata_r <= res_value;
      ouser_r <= res_ok;
    end
  end

  t2i_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (!ovalid_r || out_tready),
    .rows_ok  (rows_r >= RCW'(2)),
    .cols_ok  (cols_r >= CCW'(2)),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .emit     (emit)
  );

  t2i_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .VB       (VB),
    .RW       (4),
    .CIW      (3),
    .RCW      (RCW),
    .CCW      (CCW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .load        (in_fire),
    .in_cmd      (in_tdata[1:0]),
    .in_row      (in_tdata[5:2]),
    .in_col      (in_tdata[8:6]),
    .in_wv       (in_tdata[24:9]),
    .in_meas     (in_tdata[40:25]),
    .in_cond     (in_tdata[56:41]),
    .rows_in_use (rows_r),
    .cols_in_use (cols_r),
    .res_value   (res_value),
    .res_ok      (res_ok)
  );
endmodule

@@ rtl/t2i_divider.sv @@
`timescale 1ns / 1ps
module t2i_divider
  import t2i_pkg::*;
#(
  parameter int VB = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VB:0]      mag_a,
  input  logic [VB:0]      dx,
  input  logic [VB:0]      den,
  output logic             done,
  output logic [2*VB+1:0]  quot
);
  localparam int PW = 2 * VB + 2;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] prod_r, rem_r, quot_r;
  logic [PW:0]   trial;
  logic [CW-1:0] cnt_r;
  logic          busy_r, mul_r, done_r;

  assign trial = {rem_r, prod_r[PW-1]};
  assign done  = done_r;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mul_r  <= 1'b1;
        busy_r <= 1'b0;
      end else if (mul_r) begin
        prod_r <= PW'(mag_a) * PW'(dx);
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= CW'(PW);
        mul_r  <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        prod_r <= prod_r << 1;
        if (trial >= (PW + 1)'(den)) begin
          rem_r  <= PW'(trial - (PW + 1)'(den));
          quot_r <= {quot_r[PW-2:0], 1'b1};
        end else begin
          rem_r  <= PW'(trial);
          quot_r <= {quot_r[PW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/t2i_datapath.sv @@
`timescale 1ns / 1ps
module t2i_datapath
  import t2i_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 8,
  parameter int VB       = 16,
  parameter int RW       = 4,
  parameter int CIW      = 3,
  parameter int RCW      = 5,
  parameter int CCW      = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  t2i_cmd_t             cmd,
  output t2i_status_t          status,
  input  logic                 load,
  input  logic [1:0]           in_cmd,
  input  logic [RW-1:0]        in_row,
  input  logic [CIW-1:0]       in_col,
  input  logic signed [VB-1:0] in_wv,
  input  logic signed [VB-1:0] in_meas,
  input  logic signed [VB-1:0] in_cond,
  input  logic [RCW-1:0]       rows_in_use,
  input  logic [CCW-1:0]       cols_in_use,
  output logic signed [VB-1:0] res_value,
  output logic                 res_ok
);
  localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int QW = 2 * VB + 2;
  localparam longint VMAX_L = (longint'(1) <<< (VB - 1)) - 1;
  localparam logic signed [QW:0] SAT_HI = (QW + 1)'(VMAX_L);
  localparam logic signed [QW:0] SAT_LO = (QW + 1)'(-VMAX_L - 1);

  logic signed [VB-1:0] cell_mem [MAX_ROWS*MAX_COLS];
  logic signed [VB-1:0] rref_mem [MAX_ROWS];
  logic signed [VB-1:0] cref_mem [MAX_COLS];
  logic signed [VB-1:0] cvals_r  [MAX_COLS];

  logic [1:0]           cmd_r;
  logic [RW-1:0]        row_r;
  logic [CIW-1:0]       col_r;
  logic signed [VB-1:0] wv_r, meas_r, cond_r;
  logic [RCW-1:0]       ri_r;
  logic [CCW-1:0]       ci_r;
  logic signed [VB-1:0] rd_r, x0_r, x1_r, y0_r, y1_r;
  logic                 phase_r;
  logic signed [VB-1:0] res_r;
  logic                 ok_r;
  logic                 neg_r;

  logic signed [VB:0]   dy, dxs, dens;
  logic [VB:0]          mag, dxu, denu;
  logic                 div_done;
  logic [QW-1:0]        quot;
  logic signed [QW:0]   sum;
  logic signed [VB-1:0] lerp_val;

  logic signed [VB:0]   lx0, lx1, ly0, ly1, lx;

  logic [RCW-1:0] ri_p1;
  logic [CCW-1:0] ci_p1;
  logic [AW-1:0]  wr_addr, rd0_addr, rd1_addr;

  always_comb begin
    if (phase_r) begin
      lx0 = (VB + 1)'(x0_r); lx1 = (VB + 1)'(x1_r);
      ly0 = (VB + 1)'(y0_r); ly1 = (VB + 1)'(y1_r); lx = (VB + 1)'(meas_r);
    end else begin
      lx0 = (VB + 1)'(x0_r); lx1 = (VB + 1)'(x1_r);
      ly0 = (VB + 1)'(y0_r); ly1 = (VB + 1)'(y1_r); lx = (VB + 1)'(cond_r);
    end
    dy   = ly1 - ly0;
    dxs  = lx - lx0;
    dens = lx1 - lx0;
    mag  = dy[VB] ? (VB + 1)'(-dy) : dy;
    dxu  = dxs;
    denu = dens;
  end

  t2i_divider #(.VB(VB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .mag_a (mag),
    .dx    (dxu),
    .den   (denu),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    sum = neg_r ? (QW + 1)'(y0_r) - $signed((QW + 1)'(quot))
                : (QW + 1)'(y0_r) + $signed((QW + 1)'(quot));
    if (sum > SAT_HI)
      lerp_val = SAT_HI[VB-1:0];
    else if (sum < SAT_LO)
      lerp_val = SAT_LO[VB-1:0];
    else
      lerp_val = VB'(sum);
  end

  assign ri_p1    = ri_r + 1'b1;
  assign ci_p1    = ci_r + 1'b1;
  assign wr_addr  = AW'(row_r) * AW'(MAX_COLS) + AW'(col_r);
  assign rd0_addr = AW'(ri_r[RI-1:0]) * AW'(MAX_COLS) + AW'(ci_r[CI-1:0]);
  assign rd1_addr = AW'(ri_p1[RI-1:0]) * AW'(MAX_COLS) + AW'(ci_r[CI-1:0]);

  always_comb begin
    status.is_query = (cmd_r == CMD_QUERY);
    status.row_hit  = (x0_r <= cond_r) && (x1_r > cond_r);
    status.row_last = (RCW'(ri_r) + RCW'(2) >= rows_in_use);
    status.col_pass = phase_r;
    status.col_done = (CCW'(ci_r) + CCW'(1) >= cols_in_use);
    status.col_hit  = (cvals_r[ci_r[CI-1:0]] <= meas_r) &&
                      (cvals_r[ci_p1[CI-1:0]] > meas_r);
    status.col_last = (ci_r + CCW'(2) >= cols_in_use);
    status.div_done = div_done;
  end

  assign res_value = res_r;
  assign res_ok    = ok_r;

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r  <= in_cmd;
      row_r  <= in_row;
      col_r  <= in_col;
      wv_r   <= in_wv;
      meas_r <= in_meas;
      cond_r <= in_cond;
    end
    case (cmd.op)
      OP_WRITE: begin
        if (cmd_r == CMD_CELL && 32'(row_r) < MAX_ROWS && 32'(col_r) < MAX_COLS)
          cell_mem[wr_addr] <= wv_r;
        if (cmd_r == CMD_ROW_REF && 32'(row_r) < MAX_ROWS)
          rref_mem[RI'(row_r)] <= wv_r;
        if (cmd_r == CMD_COL_REF && 32'(col_r) < MAX_COLS)
          cref_mem[CI'(col_r)] <= wv_r;
        ri_r    <= '0;
        ci_r    <= '0;
        phase_r <= 1'b0;
        res_r   <= meas_r;
        ok_r    <= 1'b0;
      end
      OP_ROW_RD0: rd_r <= rref_mem[ri_r[RI-1:0]];
      OP_ROW_RD1: begin
        x0_r <= rd_r;
        x1_r <= rref_mem[ri_p1[RI-1:0]];
      end
      OP_ROW_TEST: begin
        if (!status.row_hit) ri_r <= ri_p1;
      end
      OP_CELL_RD0: rd_r <= cell_mem[rd0_addr];
      OP_CELL_RD1: begin
        y0_r <= rd_r;
        y1_r <= cell_mem[rd1_addr];
      end
      OP_DIV_START: neg_r <= dy[VB];
      OP_DIV_WAIT: begin
        if (div_done) begin
          if (phase_r) begin
            res_r <= lerp_val;
            ok_r  <= 1'b1;
          end else begin
            cvals_r[ci_r[CI-1:0]] <= lerp_val;
            if (status.col_done) ci_r <= '0;
            else ci_r <= ci_p1;
          end
        end
      end
      OP_COL_TEST: begin
        phase_r <= 1'b1;
        x0_r <= cvals_r[ci_r[CI-1:0]];
        x1_r <= cvals_r[ci_p1[CI-1:0]];
        if (!status.col_hit) ci_r <= ci_p1;
      end
      OP_CREF_RD0: rd_r <= cref_mem[ci_r[CI-1:0]];
      OP_CREF_RD1: begin
        y0_r <= rd_r;
        y1_r <= cref_mem[ci_p1[CI-1:0]];
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/t2i_controller.sv @@
`timescale 1ns / 1ps
module t2i_controller
  import t2i_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        out_free,
  input  logic        rows_ok,
  input  logic        cols_ok,
  input  t2i_status_t status,
  output t2i_cmd_t    cmd,
  output logic        busy,
  output logic        emit
);
  op_t  op_r;
  logic emit_r;

  assign cmd.op     = op_r;
  assign cmd.div_go = (op_r == OP_DIV_START);
  assign busy       = (op_r != OP_IDLE);
  assign emit       = emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_IDLE;
      emit_r <= 1'b0;
    end else begin
      emit_r <= 1'b0;
      case (op_r)
        OP_IDLE:    if (in_fire) op_r <= OP_WRITE;
        OP_WRITE: begin
          if (!status.is_query) op_r <= OP_IDLE;
          else if (rows_ok && cols_ok) op_r <= OP_ROW_RD0;
          else op_r <= OP_FINISH;
        end
        OP_ROW_RD0: op_r <= OP_ROW_RD1;
        OP_ROW_RD1: op_r <= OP_ROW_TEST;
        OP_ROW_TEST: begin
          if (status.row_hit) op_r <= OP_CELL_RD0;
          else if (status.row_last) op_r <= OP_FINISH;
          else op_r <= OP_ROW_RD0;
        end
        OP_CELL_RD0: op_r <= OP_CELL_RD1;
        OP_CELL_RD1: op_r <= OP_DIV_START;
        OP_DIV_START: op_r <= OP_DIV_WAIT;
        OP_DIV_WAIT: begin
          if (status.div_done) begin
            if (status.col_pass) op_r <= OP_FINISH;
            else if (status.col_done) op_r <= OP_COL_TEST;
            else op_r <= OP_CELL_RD0;
          end
        end
        OP_COL_TEST: begin
          if (status.col_hit) op_r <= OP_CREF_RD0;
          else if (status.col_last) op_r <= OP_FINISH;
          else op_r <= OP_COL_TEST;
        end
        OP_CREF_RD0: op_r <= OP_CREF_RD1;
        OP_CREF_RD1: op_r <= OP_DIV_START;
        OP_FINISH: begin
          if (out_free) begin
            emit_r <= 1'b1;
            op_r   <= OP_IDLE;
          end
        end
        default: op_r <= OP_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/t2i_checker.sv @@
`timescale 1ns / 1ps
`include "table_2d_inverse_interpolator_defines.svh"
module t2i_checker
  import t2i_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);
  `T2I_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "result dropped while stalled")
  `T2I_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "second item taken while one is in work")
  `T2I_ASSERT_NEXT(a_write_no_result,
    $past(in_tvalid && in_tready && in_tdata[1:0] != CMD_QUERY), !$rose(out_tvalid),
    "write produced a result")
endmodule

bind table_2d_inverse_interpolator t2i_checker u_chk (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import t2i_pkg::*;

  localparam int NROWS = 16;
  localparam int NCOLS = 8;
  localparam int DRAIN_CYCLES = 500;

  typedef struct {
    logic signed [15:0] value;
    logic               in_range;
  } comp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic        cfg_addr;
  logic [4:0]  cfg_wdata;

  // predictor state
  logic signed [15:0] cell_mem [NROWS][NCOLS];
  logic signed [15:0] row_ref_mem [NROWS];
  logic signed [15:0] col_ref_mem [NCOLS];
  int    rows_act;
  int    cols_act;
  comp_t comp_q[$];
  bit    idle_on;
  int    n_fail;
  int    stall_left;

  table_2d_inverse_interpolator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic signed [15:0] lin_interp(longint x0, longint y0, longint x1,
                                                    longint y1, longint x);
    longint den = x1 - x0;
    longint dx = x - x0;
    longint dy = y1 - y0;
    longint mag;
    longint q;
    mag = (dy < 0) ? -dy : dy;
    q = (mag * dx) / den;
    if (dy < 0) q = -q;
    q = y0 + q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic comp_t compensate(logic signed [15:0] meas, logic signed [15:0] cond);
    comp_t r;
    int ri;
    int ci;
    logic signed [15:0] cv [NCOLS];
    r.value = meas;
    r.in_range = 1'b0;
    ri = -1;
    ci = -1;
    for (int i = 0; i + 1 < rows_act; i++) begin
      if (ri < 0 && row_ref_mem[i] <= cond && row_ref_mem[i+1] > cond) ri = i;
    end
    if (ri >= 0) begin
      for (int j = 0; j < cols_act; j++)
        cv[j] = lin_interp(row_ref_mem[ri], cell_mem[ri][j], row_ref_mem[ri+1],
                           cell_mem[ri+1][j], cond);
      for (int j = 0; j + 1 < cols_act; j++) begin
        if (ci < 0 && cv[j] <= meas && cv[j+1] > meas) ci = j;
      end
      if (ci >= 0) begin
        r.value = lin_interp(cv[ci], col_ref_mem[ci], cv[ci+1], col_ref_mem[ci+1], meas);
        r.in_range = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_item(cmd_t cmd, logic [3:0] row, logic [2:0] col,
                           logic signed [15:0] wv, logic signed [15:0] meas,
                           logic signed [15:0] cond);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(3) == 0) gap = $urandom_range(11, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, cond, meas, wv, col, row, cmd};
    do @(posedge clk); while (!in_tready);
    case (cmd)
      CMD_QUERY:   comp_q.push_back(compensate(meas, cond));
      CMD_CELL:    cell_mem[row][col] = wv;
      CMD_ROW_REF: row_ref_mem[row] = wv;
      CMD_COL_REF: col_ref_mem[col] = wv;
    endcase
  endtask

  task automatic query(logic signed [15:0] meas, logic signed [15:0] cond);
    send_item(CMD_QUERY, 4'($urandom), 3'($urandom), 16'($urandom), meas, cond);
  endtask

  // hold input low until every result is back and the block has gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (comp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [4:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_ROWS) rows_act = (val > NROWS) ? NROWS : val;
    else cols_act = (val > NCOLS) ? NCOLS : val;
  endtask

  task automatic load_table(bit ordered);
    int base;
    for (int i = 0; i < NROWS; i++) begin
      if (i == 0) base = -32768 + $urandom_range(12000);
      else base = row_ref_mem[i-1] + $urandom_range(3000, 1);
      send_item(CMD_ROW_REF, 4'(i), 3'($urandom), ordered ? 16'(base) : 16'($urandom),
                16'($urandom), 16'($urandom));
    end
    for (int j = 0; j < NCOLS; j++)
      send_item(CMD_COL_REF, 4'($urandom), 3'(j), 16'($urandom), 16'($urandom),
                16'($urandom));
    for (int i = 0; i < NROWS; i++) begin
      for (int j = 0; j < NCOLS; j++) begin
        if (j == 0) base = -32768 + $urandom_range(20000);
        else base = cell_mem[i][j-1] + $urandom_range(5000, 1);
        send_item(CMD_CELL, 4'(i), 3'(j), ordered ? 16'(base) : 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic good_query();
    int i;
    int lo;
    int hi;
    logic signed [15:0] cond;
    i = (rows_act >= 2) ? $urandom_range(rows_act - 2) : 0;
    if (row_ref_mem[i+1] > row_ref_mem[i])
      cond = row_ref_mem[i] + $urandom_range(row_ref_mem[i+1] - row_ref_mem[i] - 1);
    else cond = row_ref_mem[i];
    lo = cell_mem[i][0] - 200;
    hi = cell_mem[i+1][NCOLS-1] + 200;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (hi < lo) hi = lo;
    query(16'(lo + $urandom_range(hi - lo)), cond);
  endtask

  task automatic test_load_and_limits();
    write_reg(REG_ROWS, 5'd16);
    write_reg(REG_COLS, 5'd8);
    load_table(1'b1);
    good_query();
    query(16'sh7fff, 16'sh7fff);
    query(16'sh8000, 16'sh8000);
    query(16'sh8000, row_ref_mem[0]);
    query(cell_mem[0][0], row_ref_mem[0]);
    query(cell_mem[0][0] - 16'sd1, row_ref_mem[0]);
    query(16'sh7fff, row_ref_mem[NROWS-1] - 16'sd1);
    query(cell_mem[3][NCOLS-1], row_ref_mem[3]);
    query(cell_mem[5][2], row_ref_mem[0] - 16'sd1);
    query(cell_mem[5][2], row_ref_mem[NROWS-1]);
    good_query();
  endtask

  task automatic test_small_counts();
    write_reg(REG_ROWS, 5'd1);
    good_query();
    write_reg(REG_ROWS, 5'd0);
    query(16'sh1234, row_ref_mem[0]);
    write_reg(REG_ROWS, 5'd2);
    write_reg(REG_COLS, 5'd1);
    good_query();
    write_reg(REG_COLS, 5'd0);
    good_query();
    write_reg(REG_COLS, 5'd2);
    good_query();
    good_query();
    write_reg(REG_ROWS, 5'd31);
    write_reg(REG_COLS, 5'd31);
    good_query();
    good_query();
  endtask

  task automatic test_overlapping_brackets();
    drain();
    // repeat a value so several column brackets fit
    send_item(CMD_CELL, 4'd0, 3'd3, cell_mem[0][1], 16'sh0, 16'sh0);
    send_item(CMD_CELL, 4'd1, 3'd3, cell_mem[1][1], 16'sh0, 16'sh0);
    send_item(CMD_CELL, 4'd0, 3'd4, cell_mem[0][2], 16'sh0, 16'sh0);
    send_item(CMD_CELL, 4'd1, 3'd4, cell_mem[1][2], 16'sh0, 16'sh0);
    send_item(CMD_ROW_REF, 4'd2, 3'd0, row_ref_mem[1], 16'sh0, 16'sh0);
    for (int k = 0; k < 6; k++) query(cell_mem[0][1] + 16'($urandom_range(8)), row_ref_mem[0]);
  endtask

  task automatic test_random(int n_items, bit ordered);
    int pick;
    load_table(ordered);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) good_query();
      else if (pick < 80) query(16'($urandom), 16'($urandom));
      else
        send_item(cmd_t'($urandom_range(3, 1)), 4'($urandom), 3'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      if (k == n_items / 2) drain();
    end
  endtask

  always @(posedge clk) begin
    comp_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (comp_q.size() == 0) begin
        $error("unexpected result value=%0d in_range=%0b", $signed(out_tdata), out_tuser);
        n_fail++;
      end else begin
        exp_r = comp_q.pop_front();
        if (out_tdata !== exp_r.value) begin
          $error("result_value expected %0d actual %0d", exp_r.value, $signed(out_tdata));
          n_fail++;
        end
        if (out_tuser !== exp_r.in_range) begin
          $error("in_range expected %0b actual %0b", exp_r.in_range, out_tuser);
          n_fail++;
        end
      end
    end
    if (!rst_n || !idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left <= $urandom_range(10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    n_fail     = 0;
    stall_left = 0;
    idle_on    = 1'b1;
    rows_act   = 0;
    cols_act   = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = 1'b0;
    cfg_wdata  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_and_limits();
    test_small_counts();
    test_overlapping_brackets();
    write_reg(REG_ROWS, 5'd16);
    write_reg(REG_COLS, 5'd8);
    test_random(250, 1'b1);
    write_reg(REG_ROWS, 5'd2);
    write_reg(REG_COLS, 5'd2);
    test_random(150, 1'b1);
    write_reg(REG_ROWS, 5'($urandom_range(31)));
    write_reg(REG_COLS, 5'($urandom_range(31)));
    test_random(120, 1'b0);
    write_reg(REG_ROWS, 5'($urandom_range(16, 2)));
    write_reg(REG_COLS, 5'($urandom_range(8, 2)));
    idle_on = 1'b0;
    test_random(240, 1'b1);
    drain();
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
